[rtl/pfs_pkg.sv]
// Shared constants, types and elaboration-time threshold tables for the sRGB8 pixel converter.
package pfs_pkg;

    // One search step per result bit; a result byte takes eight steps.
    localparam int NumSteps = 8;
    localparam int TabDepth = 256;

    // Pixel format codes held in the pixel_format register.
    localparam logic [2:0] FmtRgba8 = 3'd0;
    localparam logic [2:0] FmtR     = 3'd1;
    localparam logic [2:0] FmtRg    = 3'd2;
    localparam logic [2:0] FmtRgb   = 3'd3;
    localparam logic [2:0] FmtRgba  = 3'd4;

    // Register indexes on the configuration port.
    localparam logic RegPixelFormat   = 1'b0;
    localparam logic RegReplicateGray = 1'b1;

    // Threshold kinds used while the tables are built.
    localparam int KindLinear = 0;
    localparam int KindPower  = 1;
    localparam int KindAlpha  = 2;

    // Bytes up to this one come from the linear segment of the encode curve; all
    // higher bytes come from the power segment.
    localparam int LinearTop = 10;

    localparam int WideW      = 600;
    localparam int QDen       = 270078945;
    localparam int NOfs       = 14079945;
    localparam int LinFactor  = 330750708;
    localparam int LinScale   = 100000;
    localparam int AlphaFactor = 255999;
    localparam int AlphaScale = 1000;

    // Float bit patterns that bracket every threshold: 2^-20 lies below all of
    // them and 1.0 lies at or above all of them.
    localparam logic [30:0] SearchLo = 31'h35800000;
    localparam logic [30:0] SearchHi = 31'h3F800000;

    typedef logic [30:0] thr_tab_t [TabDepth];

    // Pipeline load enables, one per lane stage plus the output stage.
    typedef struct packed {
        logic [NumSteps:0] en;
    } pipe_ctl_t;

    function automatic logic [WideW-1:0] wide_pow(input logic [WideW-1:0] base, input int n);
        logic [WideW-1:0] acc;
        int i;
        acc = WideW'(1);
        for (i = 0; i < n; i++)
        begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // Smallest positive float, as bits, whose value reaches threshold j of the
    // given kind. The comparison is exact integer arithmetic on m * 2^-s.
    function automatic logic [30:0] find_threshold(input int kind, input int j);
        logic [WideW-1:0] factor;
        logic [WideW-1:0] base;
        logic [WideW-1:0] mant;
        logic [WideW-1:0] lhs;
        logic [WideW-1:0] rhs;
        logic [30:0] lo;
        logic [30:0] hi;
        logic [30:0] mid;
        int p;
        int s;
        int it;
        case (kind)
            KindPower:
            begin
                factor = wide_pow(WideW'(QDen), 12);
                base   = wide_pow(WideW'(NOfs) + WideW'(j) * WideW'(1000000), 12);
                p      = 5;
            end
            KindAlpha:
            begin
                factor = WideW'(AlphaFactor);
                base   = WideW'(j) * WideW'(AlphaScale);
                p      = 1;
            end
            default:
            begin
                factor = WideW'(LinFactor);
                base   = WideW'(j) * WideW'(LinScale);
                p      = 1;
            end
        endcase
        lo = SearchLo;
        hi = SearchHi;
        for (it = 0; it < 32; it++)
        begin
            if ((hi - lo) > 31'd1)
            begin
                mid  = lo + ((hi - lo) >> 1);
                mant = WideW'({1'b1, mid[22:0]});
                s    = 150 - int'(mid[30:23]);
                lhs  = wide_pow(mant, p) * factor;
                rhs  = base << (p * s);
                if (lhs >= rhs)
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid;
                end
            end
        end
        return hi;
    endfunction

    // Entry k is the lowest input whose byte is at least k; entry 0 always passes.
    function automatic thr_tab_t build_table(input logic alpha_kind);
        thr_tab_t t;
        int j;
        t[0] = 31'd0;
        for (j = 1; j < TabDepth; j++)
        begin
            if (alpha_kind)
            begin
                t[j] = find_threshold(KindAlpha, j);
            end
            else if (j <= LinearTop)
            begin
                t[j] = find_threshold(KindLinear, j);
            end
            else
            begin
                t[j] = find_threshold(KindPower, j);
            end
        end
        return t;
    endfunction

    localparam thr_tab_t SrgbThr  = build_table(1'b0);
    localparam thr_tab_t AlphaThr = build_table(1'b1);

endpackage

[rtl/pfs_ctrl.sv]
// Valid tracking and stage enables for the converter pipeline.
module pfs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output pfs_pkg::pipe_ctl_t ctl
);

    logic [pfs_pkg::NumSteps:0] valid_reg;
    logic [pfs_pkg::NumSteps:0] valid_next;
    logic [pfs_pkg::NumSteps:0] ready;

    // A stage may load when it is empty or its contents move on, so bubbles
    // collapse and new items enter while a finished result waits.
    always_comb
    begin
        ready[pfs_pkg::NumSteps] = !valid_reg[pfs_pkg::NumSteps] || !out_stall;
        for (int i = pfs_pkg::NumSteps - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i + 1];
        end
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i <= pfs_pkg::NumSteps; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.en    = ready;
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[pfs_pkg::NumSteps];

endmodule

[rtl/pfs_lane.sv]
// One channel lane: an eight-step pipelined threshold search from float bits to a byte.
module pfs_lane (
    input  logic               clk,
    input  pfs_pkg::pipe_ctl_t ctl,
    input  logic               alpha_tab,
    input  logic [31:0]        bits_in,
    output logic [7:0]         byte_out,
    output logic [31:0]        bits_out
);

    localparam int Last = pfs_pkg::NumSteps - 1;

    logic [31:0] bits_reg  [pfs_pkg::NumSteps];
    logic [31:0] bits_next [pfs_pkg::NumSteps];
    logic [7:0]  k_reg     [pfs_pkg::NumSteps];
    logic [7:0]  k_next    [pfs_pkg::NumSteps];
    logic [7:0]  cand      [pfs_pkg::NumSteps];
    logic [30:0] thr       [pfs_pkg::NumSteps];
    logic        kill;

    // Each step tries the next lower result bit. Positive float bit patterns
    // order like their values, so one unsigned compare decides the bit.
    always_comb
    begin
        for (int j = 0; j < pfs_pkg::NumSteps; j++)
        begin
            if (j == 0)
            begin
                cand[j]      = 8'(8'd1 << (pfs_pkg::NumSteps - 1));
                bits_next[j] = bits_in;
            end
            else
            begin
                cand[j]      = k_reg[j - 1] | 8'(8'd1 << (pfs_pkg::NumSteps - 1 - j));
                bits_next[j] = bits_reg[j - 1];
            end
            thr[j] = alpha_tab ? pfs_pkg::AlphaThr[cand[j]] : pfs_pkg::SrgbThr[cand[j]];
            if (bits_next[j][30:0] >= thr[j])
            begin
                k_next[j] = cand[j];
            end
            else if (j == 0)
            begin
                k_next[j] = 8'd0;
            end
            else
            begin
                k_next[j] = k_reg[j - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < pfs_pkg::NumSteps; j++)
        begin
            if (ctl.en[j])
            begin
                bits_reg[j] <= bits_next[j];
                k_reg[j]    <= k_next[j];
            end
        end
    end

    // Negative values, including negative zero and negative infinity, and every NaN give zero.
    assign kill = bits_reg[Last][31]
                  || ((bits_reg[Last][30:23] == 8'hFF) && (bits_reg[Last][22:0] != 23'd0));

    assign byte_out = kill ? 8'd0 : k_reg[Last];
    assign bits_out = bits_reg[Last];

endmodule

[rtl/pfs_merge.sv]
// Output stage: combines the lane bytes by pixel format into the registered result.
module pfs_merge (
    input  logic               clk,
    input  pfs_pkg::pipe_ctl_t ctl,
    input  logic [2:0]         pixel_format,
    input  logic               replicate_gray,
    input  logic [7:0]         lane_r,
    input  logic [7:0]         lane_g,
    input  logic [7:0]         lane_b,
    input  logic [7:0]         lane_a,
    input  logic [31:0]        packed_word,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [7:0]         alpha
);

    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [7:0] alpha_next;

    always_comb
    begin
        red_next   = 8'd0;
        green_next = 8'd0;
        blue_next  = 8'd0;
        alpha_next = 8'd0;
        case (pixel_format)
            pfs_pkg::FmtRgba8:
            begin
                red_next   = packed_word[7:0];
                green_next = packed_word[15:8];
                blue_next  = packed_word[23:16];
                alpha_next = packed_word[31:24];
            end
            pfs_pkg::FmtR:
            begin
                red_next   = lane_r;
                green_next = replicate_gray ? lane_r : 8'd0;
                blue_next  = replicate_gray ? lane_r : 8'd0;
                alpha_next = 8'hFF;
            end
            pfs_pkg::FmtRg:
            begin
                red_next   = lane_r;
                green_next = lane_g;
                alpha_next = 8'hFF;
            end
            pfs_pkg::FmtRgb:
            begin
                red_next   = lane_r;
                green_next = lane_g;
                blue_next  = lane_b;
                alpha_next = 8'hFF;
            end
            pfs_pkg::FmtRgba:
            begin
                red_next   = lane_r;
                green_next = lane_g;
                blue_next  = lane_b;
                alpha_next = lane_a;
            end
            default:
            begin
                red_next   = 8'd0;
                green_next = 8'd0;
                blue_next  = 8'd0;
                alpha_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[pfs_pkg::NumSteps])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;
    assign alpha = alpha_reg;

endmodule

[rtl/pixel_format_to_srgb8.sv]
// Top level of the float pixel to sRGB8 converter: configuration registers, lanes and output.
//
// Each input item is one pixel as four 32-bit channel words; each result item is an
// 8-bit red, green, blue and alpha. Both channels move an item at a rising edge where
// valid is high and stall is low. The APB port sets pixel_format (address 0) and
// replicate_gray (address 4); pready is tied high and writes take effect on the access
// cycle. Change them only while no item is in flight.
// Four lanes, one per channel word, run an eight-step threshold search in eight
// pipeline stages, one table compare per stage; a merge stage then registers the result.
// A result passes the lane stages and then the merge register, and the block takes one
// item every cycle for as long as the receiver keeps up.
// When out_stall is held, the result stays put and items keep entering until every
// stage is full; only then does in_stall rise, combinationally from out_stall.
// Reset empties the pipeline, drops out_valid and sets both registers to zero, which
// selects packed rgba8 pass-through.
module pixel_format_to_srgb8 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] chan_a_bits,
    input  logic [31:0] chan_b_bits,
    input  logic [31:0] chan_c_bits,
    input  logic [31:0] chan_d_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha
);

    logic [2:0]  pixel_format_reg;
    logic        replicate_gray_reg;
    logic        wr_en;
    logic        reg_index;
    logic [7:0]  byte_r;
    logic [7:0]  byte_g;
    logic [7:0]  byte_b;
    logic [7:0]  byte_a;
    logic [31:0] word_a;

    pfs_pkg::pipe_ctl_t ctl;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg   <= pfs_pkg::FmtRgba8;
            replicate_gray_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                pfs_pkg::RegPixelFormat:   pixel_format_reg   <= pwdata[2:0];
                pfs_pkg::RegReplicateGray: replicate_gray_reg <= pwdata[0];
                default:                   pixel_format_reg   <= pixel_format_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            pfs_pkg::RegPixelFormat:   prdata = {29'd0, pixel_format_reg};
            pfs_pkg::RegReplicateGray: prdata = {31'd0, replicate_gray_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    pfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // The red lane, fed by channel word a, also carries the raw word down the pipe for rgba8 pass-through.
    pfs_lane u_lane_r (
        .clk       (clk),
        .ctl       (ctl),
        .alpha_tab (1'b0),
        .bits_in   (chan_a_bits),
        .byte_out  (byte_r),
        .bits_out  (word_a)
    );

    pfs_lane u_lane_g (
        .clk       (clk),
        .ctl       (ctl),
        .alpha_tab (1'b0),
        .bits_in   (chan_b_bits),
        .byte_out  (byte_g),
        .bits_out  ()
    );

    pfs_lane u_lane_b (
        .clk       (clk),
        .ctl       (ctl),
        .alpha_tab (1'b0),
        .bits_in   (chan_c_bits),
        .byte_out  (byte_b),
        .bits_out  ()
    );

    pfs_lane u_lane_a (
        .clk       (clk),
        .ctl       (ctl),
        .alpha_tab (1'b1),
        .bits_in   (chan_d_bits),
        .byte_out  (byte_a),
        .bits_out  ()
    );

    pfs_merge u_merge (
        .clk            (clk),
        .ctl            (ctl),
        .pixel_format   (pixel_format_reg),
        .replicate_gray (replicate_gray_reg),
        .lane_r         (byte_r),
        .lane_g         (byte_g),
        .lane_b         (byte_b),
        .lane_a         (byte_a),
        .packed_word    (word_a),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha)
    );

endmodule

[tb/pixel_srgb8_checker.sv]
// Checker for the sRGB8 pixel converter: tracks the registers, predicts each pixel, compares.
module pixel_srgb8_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] chan_a_bits,
    input  logic [31:0] chan_b_bits,
    input  logic [31:0] chan_c_bits,
    input  logic [31:0] chan_d_bits,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    output int          mismatches,
    output int          pending_pixels,
    output int          checked_pixels
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WideBits  = 640;
    localparam int PowDen    = 270078945;
    localparam int PowOfs    = 14079945;
    localparam int KneeNum   = 31308;
    localparam int KneeDen   = 10000000;
    localparam int LinMul    = 330750708;
    localparam int LinDiv    = 100000;
    localparam int AlphaMul  = 255999;
    localparam int AlphaDiv  = 1000;

    typedef enum logic [1:0] {FloatLow, FloatHigh, FloatFrac} float_kind_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba8_t;

    logic [2:0] fmt_q  = pfs_pkg::FmtRgba8;
    logic       gray_q = 1'b0;
    rgba8_t     expected_pixels [$];

    initial
    begin
        mismatches     = 0;
        checked_pixels = 0;
        pending_pixels = 0;
    end

    function automatic logic [WideBits-1:0] raise_wide(input logic [WideBits-1:0] base,
                                                       input int n);
        logic [WideBits-1:0] acc;
        acc = WideBits'(1);
        repeat (n) acc = acc * base;
        return acc;
    endfunction

    // A value strictly inside (0,1) comes back as mant * 2^-shift.
    function automatic float_kind_t split_float(input logic [31:0] bits,
                                                output logic [23:0] mant, output int shift);
        logic [7:0]  ex;
        logic [22:0] fr;
        ex    = bits[30:23];
        fr    = bits[22:0];
        mant  = '0;
        shift = 0;
        if (ex == 8'hFF && fr != 0)
            return FloatLow;
        if (bits[31])
            return FloatLow;
        if (ex == 0 && fr == 0)
            return FloatLow;
        if (ex >= 8'd127)
            return FloatHigh;
        if (ex == 0)
        begin
            mant  = {1'b0, fr};
            shift = 149;
        end
        else
        begin
            mant  = {1'b1, fr};
            shift = 150 - int'(ex);
        end
        return FloatFrac;
    endfunction

    function automatic logic [7:0] encode_srgb(input logic [31:0] bits);
        logic [23:0]         m;
        int                  s;
        float_kind_t         kind;
        logic [63:0]         lin;
        logic [WideBits-1:0] lhs;
        logic [WideBits-1:0] rhs;
        int                  lo;
        int                  hi;
        int                  mid;
        kind = split_float(bits, m, s);
        if (kind == FloatLow)
            return 8'd0;
        if (kind == FloatHigh)
            return 8'd255;
        if (s >= 40 || 64'(m) * 64'(KneeDen) <= (64'(KneeNum) << s))
        begin
            if (s >= 63)
                return 8'd0;
            lin = (64'(m) * 64'(LinMul)) >> s;
            return 8'(lin / 64'(LinDiv));
        end
        // Largest byte k with m^5 * Q^12 >= (1e6*k + ofs)^12 * 2^(5s).
        lhs = raise_wide(WideBits'(m), 5) * raise_wide(WideBits'(PowDen), 12);
        lo  = 0;
        hi  = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            rhs = raise_wide(WideBits'(1000000 * mid + PowOfs), 12) << (5 * s);
            if (lhs >= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return 8'(lo);
    endfunction

    function automatic logic [7:0] scale_alpha(input logic [31:0] bits);
        logic [23:0] m;
        int          s;
        float_kind_t kind;
        logic [63:0] lin;
        kind = split_float(bits, m, s);
        if (kind == FloatLow)
            return 8'd0;
        if (kind == FloatHigh)
            return 8'd255;
        if (s >= 63)
            return 8'd0;
        lin = (64'(m) * 64'(AlphaMul)) >> s;
        return 8'(lin / 64'(AlphaDiv));
    endfunction

    function automatic rgba8_t convert_pixel(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        rgba8_t px;
        px = '0;
        case (fmt_q)
            pfs_pkg::FmtRgba8:
                px = '{red: a[7:0], green: a[15:8], blue: a[23:16], alpha: a[31:24]};
            pfs_pkg::FmtR:
            begin
                px.red   = encode_srgb(a);
                px.green = gray_q ? px.red : 8'd0;
                px.blue  = gray_q ? px.red : 8'd0;
                px.alpha = 8'd255;
            end
            pfs_pkg::FmtRg:
            begin
                px.red   = encode_srgb(a);
                px.green = encode_srgb(b);
                px.alpha = 8'd255;
            end
            pfs_pkg::FmtRgb:
            begin
                px.red   = encode_srgb(a);
                px.green = encode_srgb(b);
                px.blue  = encode_srgb(c);
                px.alpha = 8'd255;
            end
            pfs_pkg::FmtRgba:
            begin
                px.red   = encode_srgb(a);
                px.green = encode_srgb(b);
                px.blue  = encode_srgb(c);
                px.alpha = scale_alpha(d);
            end
            default:
                px = '0;
        endcase
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgba8_t want;
        if (!rst_n)
        begin
            fmt_q  = pfs_pkg::FmtRgba8;
            gray_q = 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {pfs_pkg::RegPixelFormat, 2'b00})
                    fmt_q = pwdata[2:0];
                else if (paddr == {pfs_pkg::RegReplicateGray, 2'b00})
                    gray_q = pwdata[0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result with no pixel pending: r=%0d g=%0d b=%0d a=%0d",
                           red, green, blue, alpha);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    checked_pixels++;
                    if (red !== want.red)
                    begin
                        $error("red: expected %0d, got %0d", want.red, red);
                        mismatches++;
                    end
                    if (green !== want.green)
                    begin
                        $error("green: expected %0d, got %0d", want.green, green);
                        mismatches++;
                    end
                    if (blue !== want.blue)
                    begin
                        $error("blue: expected %0d, got %0d", want.blue, blue);
                        mismatches++;
                    end
                    if (alpha !== want.alpha)
                    begin
                        $error("alpha: expected %0d, got %0d", want.alpha, alpha);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(convert_pixel(chan_a_bits, chan_b_bits,
                                                        chan_c_bits, chan_d_bits));
            pending_pixels <= expected_pixels.size();
        end
    end

endmodule

[tb/tb_pixel_format_to_srgb8.sv]
// Testbench top for the sRGB8 pixel converter: clock, reset, register writes and pixel traffic.
module tb_pixel_format_to_srgb8;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FmtSpare5 = 3'd5;
    localparam logic [2:0] FmtSpare6 = 3'd6;
    localparam logic [2:0] FmtSpare7 = 3'd7;

    // Receiver stall patterns.
    localparam int StallNone     = 0;
    localparam int StallLight    = 1;
    localparam int StallHeavy    = 2;
    localparam int StallPeriodic = 3;

    localparam int NumPhases  = 10;
    localparam int QuietLimit = 2000;
    localparam int DrainWait  = 16;
    localparam int KneeMant   = 'h4D2E1B;

    localparam logic [2:0] PhaseFmt [NumPhases] = '{
        pfs_pkg::FmtRgba, pfs_pkg::FmtRgba8, pfs_pkg::FmtR, pfs_pkg::FmtR, pfs_pkg::FmtRg,
        pfs_pkg::FmtRgb, FmtSpare7, pfs_pkg::FmtRgba, FmtSpare5, FmtSpare6
    };
    localparam logic PhaseGray [NumPhases] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                               1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    localparam int PhaseItems [NumPhases] = '{230, 230, 230, 230, 230, 230, 60, 230, 60, 60};

    localparam int NumCorners = 15;
    localparam logic [31:0] CornerWords [NumCorners] = '{
        32'h00000000, 32'h80000000, 32'h7FC00000, 32'hFFFFFFFF, 32'h7F800000,
        32'hFF800000, 32'h3F800000, 32'h7F7FFFFF, 32'h00000001, 32'h007FFFFF,
        32'h807FFFFF, 32'h3B4D2E1B, 32'h3B4D2E1C, 32'h3F7FFFFF, 32'hBF000000
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [31:0] chan_a_bits = '0;
    logic [31:0] chan_b_bits = '0;
    logic [31:0] chan_c_bits = '0;
    logic [31:0] chan_d_bits = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;

    int mismatches;
    int pending_pixels;
    int checked_pixels;
    int burst_left   = 0;
    int stall_mode   = StallNone;
    int stall_left   = 0;
    int quiet_cycles = 0;

    always #5ns clk = ~clk;

    pixel_format_to_srgb8 u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .chan_a_bits (chan_a_bits),
        .chan_b_bits (chan_b_bits),
        .chan_c_bits (chan_c_bits),
        .chan_d_bits (chan_d_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha)
    );

    pixel_srgb8_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .chan_a_bits    (chan_a_bits),
        .chan_b_bits    (chan_b_bits),
        .chan_c_bits    (chan_c_bits),
        .chan_d_bits    (chan_d_bits),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .mismatches     (mismatches),
        .pending_pixels (pending_pixels),
        .checked_pixels (checked_pixels)
    );

    // The receiver switches between free flow, light and heavy random stalls,
    // and a periodic pattern.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(StallNone, StallPeriodic);
            stall_left <= $urandom_range(50, 300);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            StallNone:  out_stall <= 1'b0;
            StallLight: out_stall <= ($urandom_range(0, 99) < 30);
            StallHeavy: out_stall <= ($urandom_range(0, 99) < 80);
            default:    out_stall <= (stall_left % 16 < 5);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("pixel_format_to_srgb8 verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Sends one pixel and holds it until accepted; a burst that runs out ends in a gap.
    task automatic push_pixel(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d);
        in_valid    <= 1'b1;
        chan_a_bits <= a;
        chan_b_bits <= b;
        chan_c_bits <= c;
        chan_d_bits <= d;
        do @(posedge clk); while (in_stall);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(60, 200);
            else
                burst_left = $urandom_range(1, 20);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Holds off new pixels until every prediction has been matched.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    // Mix of raw words, values across both curve segments, the segment knee and corners.
    function automatic logic [31:0] pick_channel();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return $urandom();
        if (sel < 60)
            return {1'b0, 8'($urandom_range(112, 126)), 23'($urandom())};
        if (sel < 72)
            return {1'b0, 8'($urandom_range(0, 118)), 23'($urandom())};
        if (sel < 82)
            return {1'b0, 8'd118, 23'(KneeMant + $urandom_range(0, 4095) - 2048)};
        if (sel < 90)
            return {1'b0, 8'd126, 23'($urandom())};
        return CornerWords[$urandom_range(0, NumCorners - 1)];
    endfunction

    initial
    begin
        int ph;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (ph = 0; ph < NumPhases; ph++)
        begin
            write_reg(pfs_pkg::RegPixelFormat, {29'd0, PhaseFmt[ph]});
            write_reg(pfs_pkg::RegReplicateGray, {31'd0, PhaseGray[ph]});
            if (ph == 0)
            begin
                for (n = 0; n < NumCorners; n++)
                    push_pixel(CornerWords[n], CornerWords[(n + 3) % NumCorners],
                               CornerWords[(n + 7) % NumCorners],
                               CornerWords[(n + 11) % NumCorners]);
            end
            for (n = 0; n < PhaseItems[ph]; n++)
            begin
                if (ph == 4 && n == PhaseItems[ph] / 2)
                    wait_drained();
                push_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel());
            end
            wait_drained();
        end
        $display("Checked %0d pixels over %0d register settings: all five formats,",
                 checked_pixels, NumPhases);
        $display("reserved codes, NaN, infinities, denormals, negatives and the curve knee.");
        if (mismatches == 0 && pending_pixels == 0)
            $display("pixel_format_to_srgb8 verification clean");
        else
            $display("pixel_format_to_srgb8 verification failed");
        $finish;
    end

endmodule
